// ----- hw/rtl/n2v_pkg.sv -----
// Shared types, widths and constants of the RGB to NV21 converter.
package n2v_pkg;

   localparam int PIXEL_WIDTH         = 8;
   localparam int LUMA_OFFSET_WIDTH   = 24;
   localparam int CHROMA_OFFSET_WIDTH = 25;
   localparam int CSR_DATA_WIDTH      = 13;
   localparam int CSR_INDEX_WIDTH     = 1;

   localparam int DEFAULT_MAX_WIDTH   = 4096;
   localparam int DEFAULT_MAX_HEIGHT  = 4096;
   localparam int RESET_FRAME_WIDTH   = 640;
   localparam int RESET_FRAME_HEIGHT  = 480;

   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One classified pixel, handed from the front end to the color datapath.
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0]         blue;
      logic [PIXEL_WIDTH-1:0]         green;
      logic [PIXEL_WIDTH-1:0]         red;
      logic [LUMA_OFFSET_WIDTH-1:0]   luma_offset;
      logic                           has_chroma;
      logic [CHROMA_OFFSET_WIDTH-1:0] chroma_offset;
      logic                           frame_end;
   } n2v_item_type;

   // Queue status seen by the back end.
   typedef struct packed {
      logic         valid;
      n2v_item_type item;
   } n2v_queue_head_type;

endpackage

// ----- hw/rtl/rgb_to_nv21_converter.sv -----
// Top level of the BGR pixel stream to NV21 converter.
//
// Pixels enter on the req_ channel in raster order, one transaction per pixel,
// and each pixel leaves as one rsp_ transaction: its luma and luma byte offset,
// and on even rows and even columns a V/U pair and the V byte offset (U sits at
// the next byte). rsp_frame_end marks the last pixel of a frame.
// The csr_ port sets frame width (index 0) and height (index 1); write it only
// while no pixel is in flight. A write between frames applies to the next one.
// Throughput is one pixel per clock while rsp_stall is low. An accepted pixel
// passes through the input queue, the weighted-sum register and the output
// register, which takes the shifted and clamped result. The raster counters
// update once per accepted pixel.
// req_stall rises only when the two-entry queue is full, so a stalled receiver
// backs up the datapath first and the front end a few pixels later; the result
// held on rsp_ stays unchanged while rsp_stall is high.
// Reset restores 640x480, empties the pipeline and restarts at frame start.
module rgb_to_nv21_converter import n2v_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [PIXEL_WIDTH-1:0]         req_blue,
   input  logic [PIXEL_WIDTH-1:0]         req_green,
   input  logic [PIXEL_WIDTH-1:0]         req_red,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [PIXEL_WIDTH-1:0]         rsp_luma,
   output logic [LUMA_OFFSET_WIDTH-1:0]   rsp_luma_offset,
   output logic                           rsp_has_chroma,
   output logic [PIXEL_WIDTH-1:0]         rsp_chroma_v,
   output logic [PIXEL_WIDTH-1:0]         rsp_chroma_u,
   output logic [CHROMA_OFFSET_WIDTH-1:0] rsp_chroma_offset,
   output logic                           rsp_frame_end
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   n2v_item_type       q_item;
   n2v_queue_head_type q_head;

   n2v_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_blue  (req_blue),
      .req_green (req_green),
      .req_red   (req_red),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   n2v_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   n2v_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_luma          (rsp_luma),
      .rsp_luma_offset   (rsp_luma_offset),
      .rsp_has_chroma    (rsp_has_chroma),
      .rsp_chroma_v      (rsp_chroma_v),
      .rsp_chroma_u      (rsp_chroma_u),
      .rsp_chroma_offset (rsp_chroma_offset),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

// ----- hw/rtl/n2v_front.sv -----
// Front end: frame registers, raster counters and buffer offset generation.
module n2v_front import n2v_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [PIXEL_WIDTH-1:0]     req_blue,
   input  logic [PIXEL_WIDTH-1:0]     req_green,
   input  logic [PIXEL_WIDTH-1:0]     req_red,
   input  logic                       q_full,
   output logic                       q_push,
   output n2v_item_type               q_item
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int SWW = (WW > CSR_DATA_WIDTH) ? WW : CSR_DATA_WIDTH;
   localparam int SHW = (HW > CSR_DATA_WIDTH) ? HW : CSR_DATA_WIDTH;
   localparam int AW  = WW + HW;
   localparam int RESET_W_SAT = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : RESET_FRAME_WIDTH;
   localparam int RESET_H_SAT = (RESET_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : RESET_FRAME_HEIGHT;
   localparam logic [CHROMA_OFFSET_WIDTH-1:0] RESET_AREA =
      CHROMA_OFFSET_WIDTH'(RESET_W_SAT * RESET_H_SAT);

   function automatic logic [WW-1:0] sat_w(input logic [CSR_DATA_WIDTH-1:0] v);
      logic [SWW-1:0] x;
      x = SWW'(v);
      if (x < SWW'(2))              return WW'(2);
      else if (x > SWW'(MAX_WIDTH)) return WW'(MAX_WIDTH);
      else                          return WW'(x);
   endfunction

   function automatic logic [HW-1:0] sat_h(input logic [CSR_DATA_WIDTH-1:0] v);
      logic [SHW-1:0] x;
      x = SHW'(v);
      if (x < SHW'(2))               return HW'(2);
      else if (x > SHW'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
      else                           return HW'(x);
   endfunction

   logic [CSR_DATA_WIDTH-1:0]      frame_width_ff, frame_width_in;
   logic [CSR_DATA_WIDTH-1:0]      frame_height_ff, frame_height_in;
   logic [CHROMA_OFFSET_WIDTH-1:0] area_ff, area_in;
   logic [CW-1:0]                  column_ff, column_in;
   logic [RW-1:0]                  row_ff, row_in;
   logic [LUMA_OFFSET_WIDTH-1:0]   luma_index_ff, luma_index_in;
   logic [CHROMA_OFFSET_WIDTH-1:0] chroma_index_ff, chroma_index_in;

   logic [WW-1:0]                  width_sat;
   logic [HW-1:0]                  height_sat;
   logic [AW-1:0]                  mul_a, mul_b, area_prod;
   logic                           accept;
   logic                           frame_start;
   logic                           chroma;
   logic                           row_last;
   logic                           frame_last;
   logic [WW-1:0]                  column_inc;
   logic [HW-1:0]                  row_inc;
   logic [LUMA_OFFSET_WIDTH-1:0]   luma_use;
   logic [CHROMA_OFFSET_WIDTH-1:0] chroma_use;

   assign width_sat  = sat_w(frame_width_ff);
   assign height_sat = sat_h(frame_height_ff);

   // Keep the chroma plane base in step with every dimension write.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      mul_a           = AW'(width_sat);
      mul_b           = AW'(height_sat);
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata;
               mul_a          = AW'(sat_w(csr_wdata));
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata;
               mul_b           = AW'(sat_h(csr_wdata));
            end
            default: begin
            end
         endcase
      end
      area_prod = mul_a * mul_b;
      area_in   = CHROMA_OFFSET_WIDTH'(area_prod);
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      frame_start = (column_ff == '0) && (row_ff == '0);
      luma_use    = frame_start ? '0 : luma_index_ff;
      chroma_use  = frame_start ? area_ff : chroma_index_ff;
      chroma      = !row_ff[0] && !column_ff[0];
      column_inc  = WW'(column_ff) + WW'(1);
      row_inc     = HW'(row_ff) + HW'(1);
      row_last    = column_inc >= width_sat;
      frame_last  = row_last && (row_inc >= height_sat);

      q_item.blue          = req_blue;
      q_item.green         = req_green;
      q_item.red           = req_red;
      q_item.luma_offset   = luma_use;
      q_item.has_chroma    = chroma;
      q_item.chroma_offset = chroma ? chroma_use : '0;
      q_item.frame_end     = frame_last;
      q_push               = accept;

      luma_index_in   = luma_use + LUMA_OFFSET_WIDTH'(1);
      chroma_index_in = chroma ? chroma_use + CHROMA_OFFSET_WIDTH'(2) : chroma_use;
      priority if (frame_last) begin
         column_in = '0;
         row_in    = '0;
      end else if (row_last) begin
         column_in = '0;
         row_in    = row_inc[RW-1:0];
      end else begin
         column_in = column_inc[CW-1:0];
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CSR_DATA_WIDTH'(RESET_FRAME_WIDTH);
         frame_height_ff <= CSR_DATA_WIDTH'(RESET_FRAME_HEIGHT);
         area_ff         <= RESET_AREA;
         column_ff       <= '0;
         row_ff          <= '0;
         luma_index_ff   <= '0;
         chroma_index_ff <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         area_ff         <= area_in;
         if (accept) begin
            column_ff       <= column_in;
            row_ff          <= row_in;
            luma_index_ff   <= luma_index_in;
            chroma_index_ff <= chroma_index_in;
         end
      end
   end

endmodule

// ----- hw/rtl/n2v_queue.sv -----
// Short FIFO between the front end and the color datapath.
module n2v_queue import n2v_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  n2v_item_type       push_item,
   output logic               full,
   input  logic               pop,
   output n2v_queue_head_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   n2v_item_type  entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full       = count_ff == NW'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + NW'(1);
         2'b01:   count_in = count_ff - NW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/n2v_back.sv -----
// Back end: two-stage color datapath (weighted sums, then shift and clamp).
module n2v_back import n2v_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  n2v_queue_head_type             head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [PIXEL_WIDTH-1:0]         rsp_luma,
   output logic [LUMA_OFFSET_WIDTH-1:0]   rsp_luma_offset,
   output logic                           rsp_has_chroma,
   output logic [PIXEL_WIDTH-1:0]         rsp_chroma_v,
   output logic [PIXEL_WIDTH-1:0]         rsp_chroma_u,
   output logic [CHROMA_OFFSET_WIDTH-1:0] rsp_chroma_offset,
   output logic                           rsp_frame_end
);

   function automatic logic [PIXEL_WIDTH-1:0] clamp_chroma(input logic signed [16:0] s);
      logic signed [9:0] x;
      x = {s[16], s[16:8]} + 10'sd128;
      if (x < 10'sd0)        return '0;
      else if (x > 10'sd255) return 8'd255;
      else                   return x[7:0];
   endfunction

   logic                           s1_valid_ff, s1_valid_in;
   logic [15:0]                    s1_luma_ff, s1_luma_in;
   logic signed [16:0]             s1_u_ff, s1_u_in;
   logic signed [16:0]             s1_v_ff, s1_v_in;
   logic [LUMA_OFFSET_WIDTH-1:0]   s1_luma_offset_ff;
   logic                           s1_has_chroma_ff;
   logic [CHROMA_OFFSET_WIDTH-1:0] s1_chroma_offset_ff;
   logic                           s1_frame_end_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_WIDTH-1:0]         luma_ff, luma_in;
   logic [PIXEL_WIDTH-1:0]         chroma_v_ff, chroma_v_in;
   logic [PIXEL_WIDTH-1:0]         chroma_u_ff, chroma_u_in;
   logic [LUMA_OFFSET_WIDTH-1:0]   luma_offset_ff;
   logic                           has_chroma_ff;
   logic [CHROMA_OFFSET_WIDTH-1:0] chroma_offset_ff;
   logic                           frame_end_ff;

   logic                           s2_ready;
   logic                           s1_ready;
   logic signed [16:0]             b_s, g_s, r_s;

   // Advance a stage whenever the one after it is empty or draining.
   assign s2_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign pop      = head.valid && s1_ready;

   always_comb begin
      b_s = signed'(17'(head.item.blue));
      g_s = signed'(17'(head.item.green));
      r_s = signed'(17'(head.item.red));
      s1_luma_in = 16'd77 * 16'(head.item.red) + 16'd150 * 16'(head.item.green)
                 + 16'd29 * 16'(head.item.blue);
      s1_u_in    = 17'sd131 * b_s - 17'sd44 * r_s - 17'sd87 * g_s;
      s1_v_in    = 17'sd131 * r_s - 17'sd110 * g_s - 17'sd21 * b_s;
      s1_valid_in = s1_ready ? pop : s1_valid_ff;
   end

   always_comb begin
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
      luma_in      = s1_luma_ff[15:8];
      chroma_v_in  = s1_has_chroma_ff ? clamp_chroma(s1_v_ff) : '0;
      chroma_u_in  = s1_has_chroma_ff ? clamp_chroma(s1_u_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_luma_ff          <= s1_luma_in;
         s1_u_ff             <= s1_u_in;
         s1_v_ff             <= s1_v_in;
         s1_luma_offset_ff   <= head.item.luma_offset;
         s1_has_chroma_ff    <= head.item.has_chroma;
         s1_chroma_offset_ff <= head.item.chroma_offset;
         s1_frame_end_ff     <= head.item.frame_end;
      end
      if (s2_ready && s1_valid_ff) begin
         luma_ff          <= luma_in;
         chroma_v_ff      <= chroma_v_in;
         chroma_u_ff      <= chroma_u_in;
         luma_offset_ff   <= s1_luma_offset_ff;
         has_chroma_ff    <= s1_has_chroma_ff;
         chroma_offset_ff <= s1_chroma_offset_ff;
         frame_end_ff     <= s1_frame_end_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_luma          = luma_ff;
   assign rsp_luma_offset   = luma_offset_ff;
   assign rsp_has_chroma    = has_chroma_ff;
   assign rsp_chroma_v      = chroma_v_ff;
   assign rsp_chroma_u      = chroma_u_ff;
   assign rsp_chroma_offset = chroma_offset_ff;
   assign rsp_frame_end     = frame_end_ff;

endmodule

// ----- hw/rtl/n2v_checker.sv -----
// Port-level checks of the converter, bound to its top level.
module n2v_checker import n2v_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [PIXEL_WIDTH-1:0]         rsp_luma,
   input logic [LUMA_OFFSET_WIDTH-1:0]   rsp_luma_offset,
   input logic                           rsp_has_chroma,
   input logic [PIXEL_WIDTH-1:0]         rsp_chroma_v,
   input logic [PIXEL_WIDTH-1:0]         rsp_chroma_u,
   input logic [CHROMA_OFFSET_WIDTH-1:0] rsp_chroma_offset,
   input logic                           rsp_frame_end
);

   // Drop any result in flight on reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A pixel without a chroma sample carries zero chroma fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_chroma) |->
         (rsp_chroma_v == '0 && rsp_chroma_u == '0 && rsp_chroma_offset == '0))
      else $error("chroma fields set on a luma-only pixel");

   // The first pixel of a frame always samples chroma.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_luma_offset == '0) |-> rsp_has_chroma)
      else $error("frame start without chroma sample");

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_luma) && $stable(rsp_luma_offset)
          && $stable(rsp_chroma_offset) && $stable(rsp_frame_end)))
      else $error("stalled result changed");

endmodule

bind rgb_to_nv21_converter n2v_checker u_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the BGR to NV21 pixel stream converter.
`timescale 1ns / 100ps

module tb;
   import n2v_pkg::*;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0]         luma;
      logic [LUMA_OFFSET_WIDTH-1:0]   luma_offset;
      logic                           has_chroma;
      logic [PIXEL_WIDTH-1:0]         chroma_v;
      logic [PIXEL_WIDTH-1:0]         chroma_u;
      logic [CHROMA_OFFSET_WIDTH-1:0] chroma_offset;
      logic                           frame_end;
   } nv21_pixel_type;

   localparam int RANDOM_PIXELS = 700;
   localparam int MAX_PRINTS    = 40;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [PIXEL_WIDTH-1:0]         req_blue = '0;
   logic [PIXEL_WIDTH-1:0]         req_green = '0;
   logic [PIXEL_WIDTH-1:0]         req_red = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [PIXEL_WIDTH-1:0]         rsp_luma;
   logic [LUMA_OFFSET_WIDTH-1:0]   rsp_luma_offset;
   logic                           rsp_has_chroma;
   logic [PIXEL_WIDTH-1:0]         rsp_chroma_v;
   logic [PIXEL_WIDTH-1:0]         rsp_chroma_u;
   logic [CHROMA_OFFSET_WIDTH-1:0] rsp_chroma_offset;
   logic                           rsp_frame_end;

   rgb_to_nv21_converter uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_blue          (req_blue),
      .req_green         (req_green),
      .req_red           (req_red),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_luma          (rsp_luma),
      .rsp_luma_offset   (rsp_luma_offset),
      .rsp_has_chroma    (rsp_has_chroma),
      .rsp_chroma_v      (rsp_chroma_v),
      .rsp_chroma_u      (rsp_chroma_u),
      .rsp_chroma_offset (rsp_chroma_offset),
      .rsp_frame_end     (rsp_frame_end)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Converter state as the testbench sees it
   logic [CSR_DATA_WIDTH-1:0] cfg_width  = CSR_DATA_WIDTH'(RESET_FRAME_WIDTH);
   logic [CSR_DATA_WIDTH-1:0] cfg_height = CSR_DATA_WIDTH'(RESET_FRAME_HEIGHT);
   int px_col     = 0;
   int px_row     = 0;
   int luma_pos   = 0;
   int chroma_pos = RESET_FRAME_WIDTH * RESET_FRAME_HEIGHT;

   nv21_pixel_type nv21_expected[$];

   int error_count    = 0;
   int pixels_sent    = 0;
   int pixels_checked = 0;
   int chroma_checked = 0;
   int frames_checked = 0;
   int csr_writes     = 0;
   bit quiet          = 1'b0;
   int hold_request   = 0;

   function automatic int dim_in_use(input logic [CSR_DATA_WIDTH-1:0] v, input int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic logic [PIXEL_WIDTH-1:0] clamp8(input int v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[PIXEL_WIDTH-1:0];
   endfunction

   function automatic nv21_pixel_type predict_pixel(input logic [7:0] b, g, r);
      nv21_pixel_type p;
      int w, h, y_sum, u_sum, v_sum;
      bit row_last, frame_last;
      w = dim_in_use(cfg_width, DEFAULT_MAX_WIDTH);
      h = dim_in_use(cfg_height, DEFAULT_MAX_HEIGHT);
      p = '0;
      if (px_col == 0 && px_row == 0) begin
         luma_pos   = 0;
         chroma_pos = w * h;
      end
      y_sum = 77 * int'(r) + 150 * int'(g) + 29 * int'(b);
      u_sum = -44 * int'(r) - 87 * int'(g) + 131 * int'(b);
      v_sum = 131 * int'(r) - 110 * int'(g) - 21 * int'(b);
      p.luma        = clamp8(y_sum >>> 8);
      p.luma_offset = luma_pos[LUMA_OFFSET_WIDTH-1:0];
      if (px_row[0] == 1'b0 && px_col[0] == 1'b0) begin
         p.has_chroma    = 1'b1;
         p.chroma_v      = clamp8((v_sum >>> 8) + 128);
         p.chroma_u      = clamp8((u_sum >>> 8) + 128);
         p.chroma_offset = chroma_pos[CHROMA_OFFSET_WIDTH-1:0];
         chroma_pos      = (chroma_pos + 2) & 32'h1FF_FFFF;
      end
      // a counter at or past the limit ends the row or frame (shrunk mid-frame)
      row_last   = (px_col + 1 >= w);
      frame_last = row_last && (px_row + 1 >= h);
      p.frame_end = frame_last;
      luma_pos = (luma_pos + 1) & 32'hFF_FFFF;
      if (frame_last) begin
         px_col     = 0;
         px_row     = 0;
         luma_pos   = 0;
         chroma_pos = w * h;
      end else if (row_last) begin
         px_col = 0;
         px_row = px_row + 1;
      end else begin
         px_col = px_col + 1;
      end
      return p;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("pixel %0d %s: got 0x%0h, want 0x%0h",
                                pixels_checked, name, got, want));
   endtask

   // Compare each accepted result transaction with the oldest expected pixel
   always @(posedge clock) begin
      nv21_pixel_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (nv21_expected.size() == 0) begin
            report_error("result transaction with no pixel outstanding");
         end else begin
            want = nv21_expected.pop_front();
            check_field("luma", 32'(rsp_luma), 32'(want.luma));
            check_field("luma_offset", 32'(rsp_luma_offset), 32'(want.luma_offset));
            check_field("has_chroma", 32'(rsp_has_chroma), 32'(want.has_chroma));
            check_field("chroma_v", 32'(rsp_chroma_v), 32'(want.chroma_v));
            check_field("chroma_u", 32'(rsp_chroma_u), 32'(want.chroma_u));
            check_field("chroma_offset", 32'(rsp_chroma_offset),
                        32'(want.chroma_offset));
            check_field("frame_end", 32'(rsp_frame_end), 32'(want.frame_end));
            if (want.has_chroma) chroma_checked++;
            if (want.frame_end) frames_checked++;
            pixels_checked++;
         end
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Receiver: random stalls, plus a long hold when a test asks for one
   int sink_stall_left = 0;
   int sink_run_left   = 0;
   int sink_hold_left  = 0;

   always @(negedge clock) begin
      if (hold_request > 0) begin
         sink_hold_left = hold_request;
         hold_request   = 0;
      end
      if (sink_hold_left > 0) begin
         sink_hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (sink_stall_left > 0) begin
         sink_stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (sink_run_left > 0) begin
            sink_run_left--;
         end else begin
            sink_run_left   = $urandom_range(0, 12);
            sink_stall_left = pick_gap();
         end
      end
   end

   // Called just after a falling edge; returns just after a falling edge with valid
   // still high, so a following transaction can go back to back.
   task automatic send_pixel(input logic [7:0] b, g, r);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_blue  <= b;
      req_green <= g;
      req_red   <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      nv21_expected.push_back(predict_pixel(b, g, r));
      pixels_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_component();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_pixel();
      send_pixel(pick_component(), pick_component(), pick_component());
   endtask

   // Stop offering and hold until every outstanding pixel has come back
   task automatic wait_drain();
      if (req_valid) req_valid <= 1'b0;
      do @(negedge clock); while (nv21_expected.size() != 0);
   endtask

   // Only while the converter is idle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_FRAME_WIDTH) cfg_width = value;
      else cfg_height = value;
      csr_writes++;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Color extremes on even columns of the reset-size frame: all four clamps
   task automatic test_color_extremes();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);     // U clamps high
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);     // V clamps low
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd255);   // U clamps low
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd0,   8'd0,   8'd255);   // V clamps high
      send_pixel(8'd255, 8'd255, 8'd255);
      wait_drain();
   endtask

   // Sizes below the minimum saturate to a 2x2 frame; the write applies mid-frame
   task automatic test_smallest_frame();
      write_csr(CSR_FRAME_WIDTH, 13'd0);
      write_csr(CSR_FRAME_HEIGHT, 13'd1);
      repeat (5) send_random_pixel();
      wait_drain();
   endtask

   // Odd width: each chroma row takes width + 1 bytes
   task automatic test_odd_width();
      write_csr(CSR_FRAME_WIDTH, 13'd3);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      wait_drain();
      repeat (7) send_random_pixel();
      wait_drain();
   endtask

   // Largest frame (oversized values saturate), then shrink it inside the frame
   task automatic test_resize_mid_frame();
      write_csr(CSR_FRAME_WIDTH, 13'h1FFF);
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
      repeat (3) send_random_pixel();
      wait_drain();
      write_csr(CSR_FRAME_WIDTH, 13'd2);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      repeat (3) send_random_pixel();
      wait_drain();
   endtask

   // Long receiver hold while pixels keep coming: the input must stall
   task automatic test_backpressure();
      write_csr(CSR_FRAME_WIDTH, 13'd6);
      write_csr(CSR_FRAME_HEIGHT, 13'd4);
      quiet        = 1'b1;
      hold_request = 60;
      repeat (24) send_random_pixel();
      wait_drain();
      quiet = 1'b0;
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_dim(input int small_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return CSR_DATA_WIDTH'($urandom_range(2, small_hi));
      if (r < 85) return CSR_DATA_WIDTH'($urandom_range(0, 1));
      if (r < 90) return 13'd4096;
      if (r < 95) return 13'h1FFF;
      return CSR_DATA_WIDTH'($urandom_range(0, 8191));
   endfunction

   // Mostly whole frames of random size, some cut short and resized mid-frame
   task automatic test_random_frames();
      int target, r, w, h, area, count;
      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         wait_drain();
         r = $urandom_range(0, 99);
         if (r < 70) begin
            write_csr(CSR_FRAME_WIDTH, pick_dim(12));
            write_csr(CSR_FRAME_HEIGHT, pick_dim(8));
         end else if (r < 80) begin
            write_csr(CSR_FRAME_WIDTH, pick_dim(12));
         end else if (r < 90) begin
            write_csr(CSR_FRAME_HEIGHT, pick_dim(8));
         end
         w    = dim_in_use(cfg_width, DEFAULT_MAX_WIDTH);
         h    = dim_in_use(cfg_height, DEFAULT_MAX_HEIGHT);
         area = w * h;
         if (area <= 200) begin
            count = area * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         end else begin
            count = $urandom_range(1, 40);
         end
         quiet = ($urandom_range(0, 4) == 0);
         repeat (count) send_random_pixel();
         quiet = 1'b0;
      end
      wait_drain();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_color_extremes();
      test_smallest_frame();
      test_odd_width();
      test_resize_mid_frame();
      test_backpressure();
      test_random_frames();
      wait_drain();
      repeat (10) @(negedge clock);
      if (nv21_expected.size() != 0)
         report_error($sformatf("%0d pixels never came back", nv21_expected.size()));
      $display("Checked %0d pixels, %0d chroma samples, %0d frame ends, %0d register writes.",
               pixels_checked, chroma_checked, frames_checked, csr_writes);
      $display("Frames from 2x2 to 4096x4096 with saturated sizes, odd widths, mid-frame resizes.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
